FILE: rtl/core/lcf_pkg.sv
// ----------------------------------------------------------------------------
// lcf_pkg: shared types and constants for the line color filter
// Color codes, configuration register indexes and reset values, and the
// threshold bundle handed to the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package lcf_pkg;

  // Field widths
  localparam int WIDTH_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int LAP_W     = 16;
  localparam int COLOR_W   = 3;

  // Default depth of the color history
  localparam int HISTORY_DEPTH_DEF = 3;

  // Color codes
  typedef enum logic [COLOR_W-1:0] {
    COLOR_OTHER = 3'd0,
    COLOR_BLACK = 3'd1,
    COLOR_WHITE = 3'd2,
    COLOR_RED   = 3'd3,
    COLOR_BLUE  = 3'd4
  } color_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MARGIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MARGIN = 2'd3;

  // Reset values of the thresholds
  localparam logic [CFG_W-1:0] BLACK_MIN_RST   = 16'd100;
  localparam logic [CFG_W-1:0] WHITE_MAX_RST   = 16'd25;
  localparam logic [CFG_W-1:0] RED_MARGIN_RST  = 16'd20;
  localparam logic [CFG_W-1:0] BLUE_MARGIN_RST = 16'd30;

  // Threshold bundle
  typedef struct packed {
    logic [CFG_W-1:0] black_min;
    logic [CFG_W-1:0] white_max;
    logic [CFG_W-1:0] red_margin;
    logic [CFG_W-1:0] blue_margin;
  } thresh_t;

endpackage

`default_nettype wire

FILE: rtl/core/line_color_filter_lap_counter.sv
// An accepted input beat passes through the input register and then the
// result register. Throughput: one beat per cycle while out_stall is low;
// the two registers decouple the two channels, so one new beat is taken
// while a result waits. The history update and lap logic sit in one stage.
// Reset (synchronous, rst_n low) restores thresholds to 100/25/20/30,
// clears history, filtered color, start flag, lap count and both valids.
// ----------------------------------------------------------------------------
// line_color_filter_lap_counter: line color filter and lap counter
// Classifies each sensor reading, filters the color over a short history
// and counts laps between the blue start line and the red finish line.
// ----------------------------------------------------------------------------
`default_nettype none

module line_color_filter_lap_counter #(
  parameter int HISTORY_DEPTH = lcf_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [lcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lcf_pkg::CFG_W-1:0]         cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [lcf_pkg::WIDTH_W-1:0]       in_red_width,
  input  wire logic [lcf_pkg::WIDTH_W-1:0]       in_blue_width,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [lcf_pkg::COLOR_W-1:0]            out_raw_color,
  output logic [lcf_pkg::COLOR_W-1:0]            out_track_color,
  output logic                                   out_start_armed,
  output logic [lcf_pkg::LAP_W-1:0]              out_lap_count,
  output logic                                   out_speed_change
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

  // Configuration registers
  lcf_pkg::thresh_t thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.black_min   <= lcf_pkg::BLACK_MIN_RST;
      thresh_r.white_max   <= lcf_pkg::WHITE_MAX_RST;
      thresh_r.red_margin  <= lcf_pkg::RED_MARGIN_RST;
      thresh_r.blue_margin <= lcf_pkg::BLUE_MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcf_pkg::REG_BLACK_MIN:   thresh_r.black_min   <= cfg_data;
        lcf_pkg::REG_WHITE_MAX:   thresh_r.white_max   <= cfg_data;
        lcf_pkg::REG_RED_MARGIN:  thresh_r.red_margin  <= cfg_data;
        lcf_pkg::REG_BLUE_MARGIN: thresh_r.blue_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic                          s1_valid_r;
  logic [lcf_pkg::WIDTH_W-1:0]   s1_red_r;
  logic [lcf_pkg::WIDTH_W-1:0]   s1_blue_r;
  logic                          advance;
  logic                          in_take;

  assign advance  = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_red_r  <= in_red_width;
      s1_blue_r <= in_blue_width;
    end
  end

  // Classify the held reading
  lcf_pkg::color_t raw;

  lcf_classify u_classify (
    .red_width  (s1_red_r),
    .blue_width (s1_blue_r),
    .thresh     (thresh_r),
    .color      (raw)
  );

  // Filter and lap state
  lcf_pkg::color_t            hist_r [HISTORY_DEPTH];
  logic [PTR_W-1:0]           ptr_r;
  logic [PTR_W-1:0]           ptr_nxt;
  lcf_pkg::color_t            filt_r;
  lcf_pkg::color_t            filt_nxt;
  logic                       start_r;
  logic                       start_nxt;
  logic [lcf_pkg::LAP_W-1:0]  laps_r;
  logic [lcf_pkg::LAP_W-1:0]  laps_nxt;
  logic                       pulse;
  logic                       agree;

  // All other entries must already hold the new color
  always_comb begin
    agree = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if ((PTR_W'(i) != ptr_r) && (hist_r[i] != raw)) begin
        agree = 1'b0;
      end
    end
  end

  // Next filtered color, start flag and lap count
  always_comb begin
    ptr_nxt   = (ptr_r == PTR_LAST) ? '0 : ptr_r + PTR_W'(1);
    filt_nxt  = agree ? raw : filt_r;
    start_nxt = start_r;
    laps_nxt  = laps_r;
    pulse     = 1'b0;
    if ((filt_nxt != lcf_pkg::COLOR_BLUE) && (filt_r == lcf_pkg::COLOR_BLUE)) begin
      start_nxt = 1'b1;
      pulse     = 1'b1;
    end
    if (start_nxt && (filt_nxt != lcf_pkg::COLOR_RED) && (filt_r == lcf_pkg::COLOR_RED)) begin
      laps_nxt  = laps_r + lcf_pkg::LAP_W'(1);
      start_nxt = 1'b0;
      pulse     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= lcf_pkg::COLOR_OTHER;
      end
      ptr_r   <= '0;
      filt_r  <= lcf_pkg::COLOR_OTHER;
      start_r <= 1'b0;
      laps_r  <= '0;
    end else if (advance) begin
      hist_r[ptr_r] <= raw;
      ptr_r         <= ptr_nxt;
      filt_r        <= filt_nxt;
      start_r       <= start_nxt;
      laps_r        <= laps_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_raw_color    <= raw;
      out_track_color  <= filt_nxt;
      out_start_armed  <= start_nxt;
      out_lap_count    <= laps_nxt;
      out_speed_change <= pulse;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lcf_classify.sv
// ----------------------------------------------------------------------------
// lcf_classify: threshold classifier
// Maps a red/blue pulse-width pair to a raw color (unsigned compares for
// black/white, signed red/blue); rules black, white, red, blue, else other.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_classify (
  input  wire logic [lcf_pkg::WIDTH_W-1:0] red_width,
  input  wire logic [lcf_pkg::WIDTH_W-1:0] blue_width,
  input  wire lcf_pkg::thresh_t            thresh,
  output lcf_pkg::color_t                  color
);

  // Two extra bits keep the margin differences from overflowing
  localparam int SW = lcf_pkg::WIDTH_W + 2;

  logic signed [SW-1:0] r_s;
  logic signed [SW-1:0] b_s;
  logic signed [SW-1:0] red_lim;
  logic signed [SW-1:0] blue_lim;
  logic                 is_black;
  logic                 is_white;
  logic                 is_red;
  logic                 is_blue;

  // Extend widths and form the margin limits
  assign r_s      = $signed({2'b00, red_width});
  assign b_s      = $signed({2'b00, blue_width});
  assign red_lim  = b_s - $signed({2'b00, thresh.red_margin});
  assign blue_lim = r_s - $signed({2'b00, thresh.blue_margin});

  assign is_black = (red_width > thresh.black_min) && (blue_width > thresh.black_min);
  assign is_white = (red_width < thresh.white_max) && (blue_width < thresh.white_max);
  assign is_red   = r_s < red_lim;
  assign is_blue  = b_s < blue_lim;

  // Pick the first rule that matches
  always_comb begin
    priority if (is_black) begin
      color = lcf_pkg::COLOR_BLACK;
    end else if (is_white) begin
      color = lcf_pkg::COLOR_WHITE;
    end else if (is_red) begin
      color = lcf_pkg::COLOR_RED;
    end else if (is_blue) begin
      color = lcf_pkg::COLOR_BLUE;
    end else begin
      color = lcf_pkg::COLOR_OTHER;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lcf_checker.sv
// ----------------------------------------------------------------------------
// lcf_checker: port-level checks for the line color filter
// Watches the top-level ports and flags reset, hold and event slips.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [lcf_pkg::COLOR_W-1:0]    out_track_color,
  input wire logic                           out_start_armed,
  input wire logic [lcf_pkg::LAP_W-1:0]      out_lap_count,
  input wire logic                           out_speed_change
);

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result beat holds its lap count
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_lap_count))
    else $error("stalled result beat changed");

  // A start event leaves the track off blue
  a_start_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_speed_change && out_start_armed |->
      out_track_color != lcf_pkg::COLOR_BLUE)
    else $error("start event while still on blue");

  // A finish event leaves the track off red
  a_finish_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_speed_change && !out_start_armed |->
      out_track_color != lcf_pkg::COLOR_RED)
    else $error("finish event while still on red");

endmodule

bind line_color_filter_lap_counter lcf_checker u_lcf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_track_color  (out_track_color),
  .out_start_armed  (out_start_armed),
  .out_lap_count    (out_lap_count),
  .out_speed_change (out_speed_change)
);

`default_nettype wire
